// ----- hw/rtl/mzr_pkg.sv -----
// ----------------------------------------------------------------------------
// mzr_pkg
// Shared types and constants of the move-to-front zero-run decoder.
// ----------------------------------------------------------------------------
package mzr_pkg;

    localparam int ALPHABET_SIZE  = 256;
    localparam int LIST_DEPTH     = 256;
    localparam int ADDR_BITS      = 8;
    localparam int BYTE_BITS      = 8;
    localparam int LEN_BITS       = 9;
    localparam int CODE_BITS      = 9;
    localparam int RUN_COUNT_BITS = 20;
    localparam int WEIGHT_BITS    = RUN_COUNT_BITS + 1;
    localparam int SUM_BITS       = RUN_COUNT_BITS + 2;
    localparam int REPEAT_BITS    = 20;
    localparam int MAP_WORDS      = 4;
    localparam int MAP_BITS       = 64;
    localparam int MAP_SEL_BITS   = 2;
    localparam int MAP_BIT_BITS   = 6;

    localparam logic [RUN_COUNT_BITS-1:0] COUNT_MAX = '1;

    // request codes
    localparam logic [1:0] REQ_START  = 2'd0;
    localparam logic [1:0] REQ_SYMBOL = 2'd1;
    localparam logic [1:0] REQ_END    = 2'd2;

    // status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [CODE_BITS-1:0] code;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0]   out_byte;
        logic [REPEAT_BITS-1:0] repeat_res;
        logic                   status;
        logic                   last;
    } out_item_t;

    typedef struct packed {
        logic                 en;
        logic [ADDR_BITS-1:0] addr;
        logic [BYTE_BITS-1:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic                 en;
        logic [ADDR_BITS-1:0] addr;
    } mem_rd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BUILD_USED,
        ST_BUILD_FREE,
        ST_RUN_OUT,
        ST_LIT_START,
        ST_LIT_GRAB,
        ST_SHIFT,
        ST_FRONT,
        ST_LIT_OUT,
        ST_ERR_OUT
    } state_t;

endpackage

// ----- hw/rtl/mzr_list_store.sv -----
// ----------------------------------------------------------------------------
// mzr_list_store
// Move-to-front list memory: one write and one registered read per cycle,
// per-entry valid bits so unwritten entries read as their own index, and a
// copy of the front entry.
// ----------------------------------------------------------------------------
module mzr_list_store (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mzr_pkg::mem_wr_t               wr,
    input  mzr_pkg::mem_rd_t               rd,
    output logic [mzr_pkg::BYTE_BITS-1:0]  rd_data,
    output logic [mzr_pkg::BYTE_BITS-1:0]  front
);
    import mzr_pkg::*;

    logic [BYTE_BITS-1:0]  list_mem [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] valid_reg;
    logic [BYTE_BITS-1:0]  rd_raw_reg;
    logic [ADDR_BITS-1:0]  rd_addr_reg;
    logic                  rd_valid_reg;
    logic [BYTE_BITS-1:0]  front_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            list_mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_raw_reg <= list_mem[rd.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_addr_reg  <= '0;
            rd_valid_reg <= 1'b0;
            front_reg    <= '0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en)
            begin
                rd_addr_reg  <= rd.addr;
                rd_valid_reg <= valid_reg[rd.addr];
            end
            if (wr.en && (wr.addr == '0))
            begin
                front_reg <= wr.data;
            end
        end
    end

    // never-written entries still hold the ascending order of reset
    assign rd_data = rd_valid_reg ? rd_raw_reg : BYTE_BITS'(rd_addr_reg);
    assign front   = front_reg;

endmodule

// ----- hw/rtl/mtf_zero_run_decoder.sv -----
// ----------------------------------------------------------------------------
// mtf_zero_run_decoder
// Move-to-front decoder with bijective zero-run digits, list held in a
// synchronous memory.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  in       | input     | in_valid / in_ready       | in_item  (req_type, code)
//  out      | output    | out_valid / out_ready     | out_item (byte, repeat, status, last)
//  cfg      | input     | cfg_we (no back-pressure) | cfg_index, cfg_data
//
// run digits, unknown requests and end items with no pending run emit no out item
// start items rebuild the list: two passes over the 256 byte values, at most one list
// write per cycle, set by the single memory write port
// a literal at position p shifts one entry per cycle, then writes the front; a
// position past the list gives a range error item; a pending run is emitted first,
// also before an end item; out_ready low stalls only the emitting states
// reset needs no clearing pass: unwritten list entries read as their index
// ----------------------------------------------------------------------------
module mtf_zero_run_decoder (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  mzr_pkg::in_item_t                     in_item,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output mzr_pkg::out_item_t                    out_item,
    input  logic                                  cfg_we,
    input  logic [mzr_pkg::MAP_SEL_BITS-1:0]      cfg_index,
    input  logic [mzr_pkg::MAP_BITS-1:0]          cfg_data
);
    import mzr_pkg::*;

    state_t                    state_reg, state_next;
    logic [MAP_BITS-1:0]       usage_reg [MAP_WORDS];
    logic [LEN_BITS-1:0]       list_len_reg, list_len_next;
    logic [RUN_COUNT_BITS-1:0] run_count_reg, run_count_next;
    logic [WEIGHT_BITS-1:0]    run_weight_reg, run_weight_next;
    logic [ADDR_BITS-1:0]      pos_reg, pos_next;
    logic                      err_reg, err_next;
    logic                      lit_pending_reg, lit_pending_next;
    logic [ADDR_BITS-1:0]      scan_reg, scan_next;
    logic [LEN_BITS-1:0]       fill_reg, fill_next;
    logic [BYTE_BITS-1:0]      byte_reg, byte_next;
    logic                      out_valid_reg, out_valid_next;
    out_item_t                 out_item_reg, out_item_next;

    mem_wr_t                   mem_wr;
    mem_rd_t                   mem_rd;
    logic [BYTE_BITS-1:0]      mem_rd_data;
    logic [BYTE_BITS-1:0]      front_byte;

    logic                      slot_free;
    logic                      out_load;
    logic                      scan_used;
    logic [SUM_BITS-1:0]       weight_shift;
    logic [SUM_BITS-1:0]       run_sum;
    logic [LEN_BITS-1:0]       pos_full;

    mzr_list_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (mem_wr),
        .rd      (mem_rd),
        .rd_data (mem_rd_data),
        .front   (front_byte)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAP_WORDS; i++)
            begin
                usage_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            usage_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            list_len_reg    <= '0;
            run_count_reg   <= '0;
            run_weight_reg  <= WEIGHT_BITS'(1);
            lit_pending_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            list_len_reg    <= list_len_next;
            run_count_reg   <= run_count_next;
            run_weight_reg  <= run_weight_next;
            lit_pending_reg <= lit_pending_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        err_reg      <= err_next;
        scan_reg     <= scan_next;
        fill_reg     <= fill_next;
        byte_reg     <= byte_next;
        out_item_reg <= out_item_next;
    end

    assign slot_free = !out_valid_reg || out_ready;
    assign scan_used = usage_reg[scan_reg[ADDR_BITS-1 -: MAP_SEL_BITS]]
                                [scan_reg[MAP_BIT_BITS-1:0]]
                       && ({1'b0, scan_reg} < LEN_BITS'(ALPHABET_SIZE));
    assign weight_shift = SUM_BITS'(run_weight_reg) << in_item.code[0];
    assign run_sum      = SUM_BITS'(run_count_reg) + weight_shift;
    assign pos_full     = in_item.code - LEN_BITS'(1);

    always_comb
    begin
        state_next       = state_reg;
        list_len_next    = list_len_reg;
        run_count_next   = run_count_reg;
        run_weight_next  = run_weight_reg;
        pos_next         = pos_reg;
        err_next         = err_reg;
        lit_pending_next = lit_pending_reg;
        scan_next        = scan_reg;
        fill_next        = fill_reg;
        byte_next        = byte_reg;
        out_load         = 1'b0;
        out_item_next    = out_item_reg;
        mem_wr           = '0;
        mem_rd           = '0;
        in_ready         = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_item.req_type)
                        REQ_START:
                        begin
                            scan_next       = '0;
                            fill_next       = '0;
                            run_count_next  = '0;
                            run_weight_next = WEIGHT_BITS'(1);
                            state_next      = ST_BUILD_USED;
                        end
                        REQ_SYMBOL:
                        begin
                            if (in_item.code < CODE_BITS'(2))
                            begin
                                run_count_next = (run_sum > SUM_BITS'(COUNT_MAX))
                                                 ? COUNT_MAX
                                                 : run_sum[RUN_COUNT_BITS-1:0];
                                // weight stops at 2^RUN_COUNT_BITS
                                if (!run_weight_reg[WEIGHT_BITS-1])
                                begin
                                    run_weight_next = run_weight_reg << 1;
                                end
                            end
                            else
                            begin
                                pos_next         = pos_full[ADDR_BITS-1:0];
                                err_next         = (pos_full >= list_len_reg);
                                run_weight_next  = WEIGHT_BITS'(1);
                                lit_pending_next = 1'b1;
                                state_next       = (run_count_reg != '0)
                                                   ? ST_RUN_OUT : ST_LIT_START;
                            end
                        end
                        REQ_END:
                        begin
                            run_weight_next  = WEIGHT_BITS'(1);
                            lit_pending_next = 1'b0;
                            if (run_count_reg != '0)
                            begin
                                state_next = ST_RUN_OUT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // first pass: used values in ascending order
            ST_BUILD_USED:
            begin
                if (scan_used)
                begin
                    mem_wr    = '{en: 1'b1, addr: fill_reg[ADDR_BITS-1:0], data: scan_reg};
                    fill_next = fill_reg + LEN_BITS'(1);
                end
                scan_next = scan_reg + ADDR_BITS'(1);
                if (scan_reg == '1)
                begin
                    list_len_next = fill_reg + LEN_BITS'(scan_used);
                    state_next    = ST_BUILD_FREE;
                end
            end

            // second pass: the unused values fill the rest
            ST_BUILD_FREE:
            begin
                if (!scan_used)
                begin
                    mem_wr    = '{en: 1'b1, addr: fill_reg[ADDR_BITS-1:0], data: scan_reg};
                    fill_next = fill_reg + LEN_BITS'(1);
                end
                scan_next = scan_reg + ADDR_BITS'(1);
                if (scan_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_RUN_OUT:
            begin
                if (slot_free)
                begin
                    out_load       = 1'b1;
                    out_item_next  = '{out_byte:   front_byte,
                                       repeat_res: REPEAT_BITS'(run_count_reg),
                                       status:     STATUS_OK,
                                       last:       !lit_pending_reg};
                    run_count_next = '0;
                    state_next     = lit_pending_reg ? ST_LIT_START : ST_IDLE;
                end
            end

            ST_LIT_START:
            begin
                if (err_reg)
                begin
                    state_next = ST_ERR_OUT;
                end
                else
                begin
                    mem_rd     = '{en: 1'b1, addr: pos_reg};
                    state_next = ST_LIT_GRAB;
                end
            end

            ST_LIT_GRAB:
            begin
                byte_next = mem_rd_data;
                if (pos_reg == '0)
                begin
                    state_next = ST_LIT_OUT;
                end
                else
                begin
                    mem_rd     = '{en: 1'b1, addr: pos_reg - ADDR_BITS'(1)};
                    state_next = ST_SHIFT;
                end
            end

            // entry pos-1 lands in pos while pos-2 is being read
            ST_SHIFT:
            begin
                mem_wr   = '{en: 1'b1, addr: pos_reg, data: mem_rd_data};
                pos_next = pos_reg - ADDR_BITS'(1);
                if (pos_reg == ADDR_BITS'(1))
                begin
                    state_next = ST_FRONT;
                end
                else
                begin
                    mem_rd = '{en: 1'b1, addr: pos_reg - ADDR_BITS'(2)};
                end
            end

            ST_FRONT:
            begin
                mem_wr     = '{en: 1'b1, addr: '0, data: byte_reg};
                state_next = ST_LIT_OUT;
            end

            ST_LIT_OUT:
            begin
                if (slot_free)
                begin
                    out_load      = 1'b1;
                    out_item_next = '{out_byte:   byte_reg,
                                      repeat_res: REPEAT_BITS'(1),
                                      status:     STATUS_OK,
                                      last:       1'b1};
                    state_next    = ST_IDLE;
                end
            end

            ST_ERR_OUT:
            begin
                if (slot_free)
                begin
                    out_load      = 1'b1;
                    out_item_next = '{out_byte:   '0,
                                      repeat_res: '0,
                                      status:     STATUS_RANGE,
                                      last:       1'b1};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && !out_ready);
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ----- hw/rtl/mzr_checker.sv -----
// ----------------------------------------------------------------------------
// mzr_checker
// Port-level checks of the move-to-front zero-run decoder, bound to the top.
// ----------------------------------------------------------------------------
module mzr_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  mzr_pkg::in_item_t                 in_item,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  mzr_pkg::out_item_t                out_item
);
    import mzr_pkg::*;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result item changed while stalled");

    // a range error is always the closing, empty item
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status == STATUS_RANGE) |->
            out_item.last && (out_item.out_byte == '0) && (out_item.repeat_res == '0))
        else $error("malformed range error item");

    // a leading item is always a non-empty run
    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.last |->
            (out_item.status == STATUS_OK) && (out_item.repeat_res != '0))
        else $error("leading item is not a run");

    // a start item rebuilds the list before the next item is taken
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_item.req_type == REQ_START) |=> !in_ready)
        else $error("item taken during list build");

endmodule

bind mtf_zero_run_decoder mzr_checker u_mzr_checker (.*);

// ----- sim/mtf_zero_run_decoder_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mtf_zero_run_decoder_tb
// Drives symbol codes, start and end items into the move-to-front zero-run
// decoder under several usage maps and checks every out item against a
// predictor that tracks the list, the pending run and the run weight.
// ----------------------------------------------------------------------------
module mtf_zero_run_decoder_tb;

    import mzr_pkg::*;

    localparam logic [1:0]      REQ_UNUSED   = 2'd3;
    localparam longint unsigned WEIGHT_LIMIT = 64'd1 << RUN_COUNT_BITS;
    localparam int              CYCLE_LIMIT  = 2000000;
    localparam int              DRAIN_CYCLES = 600;
    localparam int              LONG_HOLD    = 400;

    class mzr_scoreboard;
        logic [MAP_BITS-1:0]       usage [MAP_WORDS];
        logic [BYTE_BITS-1:0]      order [LIST_DEPTH];
        int                        list_len;
        logic [RUN_COUNT_BITS-1:0] run_count;
        logic [WEIGHT_BITS-1:0]    run_weight;
        out_item_t                 expected_q [$];
        int                        errors;

        function new();
            for (int i = 0; i < LIST_DEPTH; i++)
                order[i] = i[BYTE_BITS-1:0];
            for (int k = 0; k < MAP_WORDS; k++)
                usage[k] = '0;
            list_len   = 0;
            run_count  = '0;
            run_weight = WEIGHT_BITS'(1);
            errors     = 0;
        endfunction

        function void write_map(int idx, logic [MAP_BITS-1:0] value);
            usage[idx] = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // used values first, then the unused ones, both ascending
        function void build_list();
            int n;
            n = 0;
            for (int v = 0; v < ALPHABET_SIZE; v++)
                if (usage[v / MAP_BITS][v % MAP_BITS])
                begin
                    order[n] = v[BYTE_BITS-1:0];
                    n++;
                end
            list_len = n;
            for (int v = 0; v < ALPHABET_SIZE; v++)
                if (!usage[v / MAP_BITS][v % MAP_BITS])
                begin
                    order[n] = v[BYTE_BITS-1:0];
                    n++;
                end
        endfunction

        function void add_result(logic [BYTE_BITS-1:0] value, logic [REPEAT_BITS-1:0] count,
                                 logic st, logic lst);
            out_item_t e;
            e.out_byte   = value;
            e.repeat_res = count;
            e.status     = st;
            e.last       = lst;
            expected_q.push_back(e);
        endfunction

        function void note_input(in_item_t it);
            longint unsigned total;
            int              pos;
            logic [BYTE_BITS-1:0] moved;
            case (it.req_type)
                REQ_START:
                begin
                    build_list();
                    run_count  = '0;
                    run_weight = WEIGHT_BITS'(1);
                end
                REQ_END:
                begin
                    if (run_count != 0)
                        add_result(order[0], run_count, STATUS_OK, 1'b1);
                    run_count  = '0;
                    run_weight = WEIGHT_BITS'(1);
                end
                REQ_SYMBOL:
                begin
                    if (it.code < 2)
                    begin
                        // run digit: weight for code 0, twice weight for code 1
                        total = 64'(run_count) + (64'(run_weight) << it.code[0]);
                        run_count = (total > 64'(COUNT_MAX)) ? COUNT_MAX
                                                             : total[RUN_COUNT_BITS-1:0];
                        total = 64'(run_weight) * 2;
                        if (total > WEIGHT_LIMIT)
                            total = WEIGHT_LIMIT;
                        run_weight = total[WEIGHT_BITS-1:0];
                    end
                    else
                    begin
                        if (run_count != 0)
                            add_result(order[0], run_count, STATUS_OK, 1'b0);
                        run_count  = '0;
                        run_weight = WEIGHT_BITS'(1);
                        pos = int'(it.code) - 1;
                        if (pos >= list_len)
                            add_result('0, '0, STATUS_RANGE, 1'b1);
                        else
                        begin
                            moved = order[pos];
                            for (int i = pos; i > 0; i--)
                                order[i] = order[i-1];
                            order[0] = moved;
                            add_result(moved, REPEAT_BITS'(1), STATUS_OK, 1'b1);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected out item: byte %0d repeat %0d status %0d",
                         $time, got.out_byte, got.repeat_res, got.status,
                         " last %0d", got.last);
                return;
            end
            want = expected_q.pop_front();
            if (got.out_byte !== want.out_byte || got.repeat_res !== want.repeat_res ||
                got.status !== want.status || got.last !== want.last)
            begin
                errors++;
                $display("%0t: out item mismatch: expected byte %0d repeat %0d status %0d",
                         $time, want.out_byte, want.repeat_res, want.status,
                         " last %0d, got byte %0d repeat %0d status %0d last %0d",
                         want.last, got.out_byte, got.repeat_res, got.status, got.last);
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    in_item_t                in_item;
    logic                    out_valid;
    logic                    out_ready;
    out_item_t               out_item;
    logic                    cfg_we;
    logic [MAP_SEL_BITS-1:0] cfg_index;
    logic [MAP_BITS-1:0]     cfg_data;

    mzr_scoreboard board = new();

    bit gaps_on;
    bit stall_on;
    int hold_requests;
    int hold_seen;
    int hold_left;
    int cycle_count;

    mtf_zero_run_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            board.check_result(out_item);

    // receiver: random stalls, plus a long hold-off whenever one is requested
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= !(stall_on && $urandom_range(99) < 15);
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input logic [1:0] req, input logic [CODE_BITS-1:0] value);
        in_item_t it;
        it.req_type = req;
        it.code     = value;
        while (gaps_on && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            in_item  <= {2'($urandom_range(3)), 9'($urandom_range(511))};
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_input(it);
        @(negedge clk);
    endtask

    // wait until every item has come out and the block has finished any list build
    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic load_map(input logic [MAP_BITS-1:0] w0, w1, w2, w3);
        logic [MAP_BITS-1:0] words [MAP_WORDS];
        words = '{w0, w1, w2, w3};
        for (int k = 0; k < MAP_WORDS; k++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= k[MAP_SEL_BITS-1:0];
            cfg_data  <= words[k];
            board.write_map(k, words[k]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [MAP_BITS-1:0] rand_word(int density);
        logic [MAP_BITS-1:0] a;
        logic [MAP_BITS-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case (density)
            0:       return a & b & {$urandom, $urandom};
            1:       return a;
            default: return a | b;
        endcase
    endfunction

    // mostly positions inside the list, shallow ones favoured, some past the end
    function automatic logic [CODE_BITS-1:0] literal_code();
        int len;
        int pos;
        len = board.list_len;
        if (len < 2 || $urandom_range(9) == 0)
            return CODE_BITS'($urandom_range(2, 511));
        if ($urandom_range(1))
            pos = $urandom_range(1, (len - 1 < 7) ? len - 1 : 7);
        else
            pos = $urandom_range(1, len - 1);
        return CODE_BITS'(pos + 1);
    endfunction

    task automatic random_phase(input int n_items, input int hold_at);
        int  sent;
        int  r;
        int  len;
        bit  held;
        sent = 0;
        held = 1'b0;
        send_item(REQ_START, CODE_BITS'($urandom_range(511)));
        sent++;
        while (sent < n_items)
        begin
            if (!held && sent >= hold_at)
            begin
                held = 1'b1;
                hold_requests++;
            end
            r = $urandom_range(99);
            if (r < 35)
            begin
                // zero run, now and then long enough to saturate
                len = ($urandom_range(14) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 4);
                repeat (len)
                    send_item(REQ_SYMBOL, CODE_BITS'($urandom_range(1)));
                sent += len;
            end
            else if (r < 75)
            begin
                send_item(REQ_SYMBOL, literal_code());
                sent++;
            end
            else if (r < 85)
            begin
                send_item(REQ_END, CODE_BITS'($urandom_range(511)));
                sent++;
            end
            else if (r < 88)
            begin
                send_item(REQ_START, CODE_BITS'($urandom_range(511)));
                sent++;
            end
            else if (r < 93)
                send_item(REQ_UNUSED, CODE_BITS'($urandom_range(511)));
            else
            begin
                send_item(REQ_SYMBOL, CODE_BITS'($urandom_range(2, 511)));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_item       = '0;
        out_ready     = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        gaps_on       = 1'b1;
        stall_on      = 1'b1;
        hold_requests = 0;
        hold_seen     = 0;
        hold_left     = 0;
        cycle_count   = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty list straight after reset: runs use the front byte, literals are out of range
        send_item(REQ_SYMBOL, CODE_BITS'(0));
        send_item(REQ_SYMBOL, CODE_BITS'(2));
        send_item(REQ_UNUSED, '1);
        send_item(REQ_END, CODE_BITS'(0));
        send_item(REQ_SYMBOL, CODE_BITS'(1));
        send_item(REQ_END, '1);
        settle();

        load_map('1, '1, '1, '1);
        send_item(REQ_START, '1);
        send_item(REQ_SYMBOL, CODE_BITS'(2));
        send_item(REQ_SYMBOL, CODE_BITS'(256));
        send_item(REQ_SYMBOL, CODE_BITS'(257));
        send_item(REQ_SYMBOL, CODE_BITS'(0));
        send_item(REQ_SYMBOL, CODE_BITS'(1));
        send_item(REQ_SYMBOL, CODE_BITS'(3));
        // count and weight both saturate
        repeat (21) send_item(REQ_SYMBOL, CODE_BITS'(1));
        send_item(REQ_END, CODE_BITS'(0));
        settle();

        load_map('0, '0, '0, '0);
        random_phase(60, 1000);
        settle();

        load_map('1, '1, '1, '1);
        random_phase(200, 80);
        settle();

        load_map('0, '0, '0, 64'd1 << 63);
        random_phase(60, 1000);
        settle();

        load_map(rand_word(0), rand_word(0), rand_word(0), rand_word(0));
        random_phase(150, 1000);
        settle();

        gaps_on  = 1'b0;
        stall_on = 1'b0;
        load_map(rand_word(2), rand_word(2), rand_word(2), rand_word(2));
        random_phase(150, 1000);
        settle();
        gaps_on  = 1'b1;
        stall_on = 1'b1;

        load_map(64'd1, '0, 64'd1, '0);
        random_phase(60, 1000);
        settle();

        load_map(rand_word(1), rand_word(1), rand_word(1), rand_word(1));
        random_phase(200, 1000);
        settle();

        load_map('0, '1, '0, '0);
        random_phase(100, 1000);
        settle();

        load_map('1, '1, '1, '1);
        random_phase(120, 1000);
        settle();

        if (board.errors == 0 && board.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
